// File: hw/rtl/pfpa_pkg.sv
package pfpa_pkg;

	localparam int unsigned DEF_POOL_DEPTH  = 1024;
	localparam int unsigned DEF_FRAME_BYTES = 2097152;

	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned TYPE_W   = 4;
	localparam int unsigned FREE_W   = 11;

	localparam logic [TYPE_W-1:0] REGION_USABLE = 4'd1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_LOAD,
		S_POP
	} state_t;

	typedef struct packed {
		logic capture;
		logic push_load;
		logic push_free;
		logic pop;
		logic respond;
		logic resp_ram;
		st_t  resp_status;
	} cmd_t;

	typedef struct packed {
		op_t  opcode;
		logic usable;
		logic empty;
		logic full;
		logic left_ge_fb;
		logic addr_fits;
		logic addr_last;
	} sts_t;

endpackage

// File: hw/rtl/physical_frame_pool_allocator_core.sv
// channel   | handshake           | words
// ----------+---------------------+---------------------------------------------------
// command   | start / busy        | opcode, region_base, region_length, region_type,
//           |                     | free_address
// result    | done (one cycle)    | frame_address, status, frames_free
//
// a word is taken at a clock edge with start high and busy low
// free, no-op, unusable load, alloc on empty pool: answered in the decode state, done registered
// alloc with a frame waits on the registered ram read: answered in the pop state, done registered
// usable load pushes one frame per cycle: done is registered once the load state stops,
// answered with the last push itself when that frame ends at the top of the address space
// reset clears the frame count and the strobe; done cannot be held off by the receiver
module physical_frame_pool_allocator_core #(
	parameter int unsigned POOL_DEPTH  = pfpa_pkg::DEF_POOL_DEPTH,
	parameter int unsigned FRAME_BYTES = pfpa_pkg::DEF_FRAME_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [pfpa_pkg::ADDR_W-1:0]    region_base,
	input  logic [pfpa_pkg::ADDR_W-1:0]    region_length,
	input  logic [pfpa_pkg::TYPE_W-1:0]    region_type,
	input  logic [pfpa_pkg::ADDR_W-1:0]    free_address,
	output logic                           done,
	output logic [pfpa_pkg::ADDR_W-1:0]    frame_address,
	output logic [1:0]                     status,
	output logic [pfpa_pkg::FREE_W-1:0]    frames_free
);

	import pfpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pfpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfpa_dp #(
		.POOL_DEPTH  (POOL_DEPTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.region_base   (region_base),
		.region_length (region_length),
		.region_type   (region_type),
		.free_address  (free_address),
		.done          (done),
		.frame_address (frame_address),
		.status        (status),
		.frames_free   (frames_free)
	);

endmodule

// File: hw/rtl/pfpa_ram.sv
module pfpa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: hw/rtl/pfpa_ctrl.sv
module pfpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pfpa_pkg::sts_t sts,
	output pfpa_pkg::cmd_t cmd
);

	import pfpa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.opcode)
					OP_LOAD:  state_d = sts.usable ? S_LOAD : S_IDLE;
					OP_ALLOC: state_d = sts.empty ? S_IDLE : S_POP;
					OP_FREE:  state_d = S_IDLE;
					OP_NOP:   state_d = S_IDLE;
				endcase
			end
			S_LOAD: begin
				if (!sts.left_ge_fb || !sts.addr_fits || sts.full || sts.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_POP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.resp_status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_DECODE: begin
				unique case (sts.opcode)
					OP_LOAD: begin
						cmd.respond = !sts.usable;
					end
					OP_ALLOC: begin
						if (sts.empty) begin
							cmd.respond     = 1'b1;
							cmd.resp_status = ST_EMPTY;
						end else begin
							cmd.pop = 1'b1;
						end
					end
					OP_FREE: begin
						cmd.respond = 1'b1;
						if (sts.full) begin
							cmd.resp_status = ST_FULL;
						end else begin
							cmd.push_free = 1'b1;
						end
					end
					OP_NOP: begin
						cmd.respond = 1'b1;
					end
				endcase
			end
			S_LOAD: begin
				priority if (!sts.left_ge_fb || !sts.addr_fits) begin
					cmd.respond = 1'b1;
				end else if (sts.full) begin
					cmd.respond     = 1'b1;
					cmd.resp_status = ST_FULL;
				end else begin
					cmd.push_load = 1'b1;
					cmd.respond   = sts.addr_last;
				end
			end
			S_POP: begin
				cmd.respond  = 1'b1;
				cmd.resp_ram = 1'b1;
			end
			default: begin
				cmd.respond = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// leaving a busy state always answers the word
	a_exit_responds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_d == S_IDLE) |-> cmd.respond)
		else $error("busy state left without a response");

	// a pop is always followed by its response
	a_pop_then_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (state_q == S_POP && cmd.respond && cmd.resp_ram))
		else $error("pop not followed by ram response");

	// answering the word returns to idle
	a_resp_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |-> (state_d == S_IDLE))
		else $error("response without return to idle");

endmodule

// File: hw/rtl/pfpa_dp.sv
module pfpa_dp #(
	parameter int unsigned POOL_DEPTH  = pfpa_pkg::DEF_POOL_DEPTH,
	parameter int unsigned FRAME_BYTES = pfpa_pkg::DEF_FRAME_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfpa_pkg::cmd_t                 cmd,
	output pfpa_pkg::sts_t                 sts,
	input  logic [1:0]                     opcode,
	input  logic [pfpa_pkg::ADDR_W-1:0]    region_base,
	input  logic [pfpa_pkg::ADDR_W-1:0]    region_length,
	input  logic [pfpa_pkg::TYPE_W-1:0]    region_type,
	input  logic [pfpa_pkg::ADDR_W-1:0]    free_address,
	output logic                           done,
	output logic [pfpa_pkg::ADDR_W-1:0]    frame_address,
	output logic [1:0]                     status,
	output logic [pfpa_pkg::FREE_W-1:0]    frames_free
);

	import pfpa_pkg::*;

	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(POOL_DEPTH);
	localparam logic [ADDR_W-1:0] FB = ADDR_W'(FRAME_BYTES);
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
	localparam logic [ADDR_W-1:0] ADDR_FIT_MAX = ADDR_MAX - FB + ADDR_W'(1);
	localparam logic [ADDR_W-1:0] ADDR_LAST_MIN = ADDR_MAX - FB;

	op_t                 opcode_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   left_q;
	logic [TYPE_W-1:0]   type_q;
	logic [ADDR_W-1:0]   free_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [CW-1:0]       count_m1;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [ADDR_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]   ram_rdata;
	logic                done_q;
	logic [ADDR_W-1:0]   frame_address_q;
	logic [1:0]          status_q;
	logic [FREE_W-1:0]   frames_free_q;

	// captured word and load walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q <= op_t'(opcode);
			addr_q   <= region_base;
			left_q   <= region_length;
			type_q   <= region_type;
			free_q   <= free_address;
		end else if (cmd.push_load) begin
			addr_q <= addr_q + FB;
			left_q <= left_q - FB;
		end
	end

	assign count_m1 = count_q - CW'(1);

	always_comb begin
		count_d = count_q;
		if (cmd.push_load || cmd.push_free) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_d = count_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign ram_we    = cmd.push_load || cmd.push_free;
	assign ram_addr  = cmd.pop ? count_m1[AW-1:0] : count_q[AW-1:0];
	assign ram_wdata = cmd.push_load ? addr_q : free_q;

	pfpa_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (POOL_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign sts.opcode     = opcode_q;
	assign sts.usable     = (type_q == REGION_USABLE);
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == FULL_CNT);
	assign sts.left_ge_fb = (left_q >= FB);
	assign sts.addr_fits  = (addr_q <= ADDR_FIT_MAX);
	assign sts.addr_last  = (addr_q > ADDR_LAST_MIN);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			frame_address_q <= cmd.resp_ram ? ram_rdata : '0;
			status_q        <= cmd.resp_status;
			frames_free_q   <= FREE_W'(count_d);
		end
	end

	assign done          = done_q;
	assign frame_address = frame_address_q;
	assign status        = status_q;
	assign frames_free   = frames_free_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("frame count beyond pool depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_load || cmd.push_free) |-> !sts.full)
		else $error("push into full pool");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.empty)
		else $error("pop from empty pool");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held two cycles");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pfpa_pkg::*;

	localparam int unsigned POOL_SLOTS   = DEF_POOL_DEPTH;
	localparam logic [63:0] FRAME        = 64'(DEF_FRAME_BYTES);
	localparam logic [63:0] TOP_FRAME    = 64'hFFFF_FFFF_FFFF_FFFF - FRAME + 64'd1;
	localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT  = 3000000;
	localparam int unsigned PHASE_WORDS  = 300;
	localparam int unsigned SETTLE       = 10;

	typedef struct {
		op_t         opcode;
		logic [63:0] base;
		logic [63:0] length;
		logic [3:0]  rtype;
		logic [63:0] faddr;
		int unsigned gap;
		bit          drain;
	} cmd_word_t;

	typedef struct packed {
		logic [63:0]       addr;
		st_t               status;
		logic [FREE_W-1:0] frames;
	} pool_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          opcode = OP_NOP;
	logic [ADDR_W-1:0]   region_base = '0;
	logic [ADDR_W-1:0]   region_length = '0;
	logic [TYPE_W-1:0]   region_type = '0;
	logic [ADDR_W-1:0]   free_address = '0;
	logic                done;
	logic [ADDR_W-1:0]   frame_address;
	logic [1:0]          status;
	logic [FREE_W-1:0]   frames_free;

	cmd_word_t           word_q[$];
	pool_reply_t         reply_q[$];
	logic [63:0]         pool_frames[POOL_SLOTS];
	int unsigned         pool_count = 0;
	int unsigned         err_count = 0;
	int unsigned         cycle_count = 0;
	int unsigned         burst_left = 0;
	logic                word_taken = 1'b0;
	bit                  have_word = 1'b0;
	int unsigned         wait_left = 0;
	cmd_word_t           cur;

	physical_frame_pool_allocator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.region_base   (region_base),
		.region_length (region_length),
		.region_type   (region_type),
		.free_address  (free_address),
		.done          (done),
		.frame_address (frame_address),
		.status        (status),
		.frames_free   (frames_free)
	);

	initial forever #10 clk = ~clk;

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic pool_reply_t pool_step(op_t op, logic [63:0] base, logic [63:0] len,
			logic [3:0] rtype, logic [63:0] faddr);
		pool_reply_t r;
		logic [63:0] a;
		logic [63:0] left;
		bit          stop;
		r.addr = '0;
		r.status = ST_DONE;
		case (op)
		OP_LOAD: begin
			if (rtype == REGION_USABLE) begin
				a = base;
				left = len;
				stop = 1'b0;
				while (!stop && left >= FRAME) begin
					if (a > TOP_FRAME) begin
						stop = 1'b1;
					end else if (pool_count >= POOL_SLOTS) begin
						r.status = ST_FULL;
						stop = 1'b1;
					end else begin
						pool_frames[pool_count] = a;
						pool_count++;
						left = left - FRAME;
						if (a >= TOP_FRAME)
							stop = 1'b1;
						else
							a = a + FRAME;
					end
				end
			end
		end
		OP_ALLOC: begin
			if (pool_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				pool_count--;
				r.addr = pool_frames[pool_count];
			end
		end
		OP_FREE: begin
			if (pool_count >= POOL_SLOTS) begin
				r.status = ST_FULL;
			end else begin
				pool_frames[pool_count] = faddr;
				pool_count++;
			end
		end
		default: ;
		endcase
		r.frames = FREE_W'(pool_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= 100)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	task automatic add_word(input op_t op, input logic [63:0] base, input logic [63:0] len,
			input logic [3:0] rtype, input logic [63:0] faddr, input bit drain);
		cmd_word_t w;
		if (burst_left == 0 && $urandom_range(0, 29) == 0)
			burst_left = $urandom_range(10, 40);
		w.opcode = op;
		w.base = base;
		w.length = len;
		w.rtype = rtype;
		w.faddr = faddr;
		w.drain = drain;
		if (burst_left != 0) begin
			w.gap = 0;
			burst_left--;
		end else begin
			w.gap = $urandom_range(0, 6);
		end
		word_q.push_back(w);
	endtask

	task automatic add_random(input bit fill_phase);
		int unsigned pick;
		int unsigned kind;
		op_t         op;
		logic [63:0] base;
		logic [63:0] len;
		logic [3:0]  rtype;
		pick = $urandom_range(0, 99);
		if (fill_phase)
			op = pick < 30 ? OP_ALLOC : pick < 60 ? OP_LOAD : pick < 95 ? OP_FREE : OP_NOP;
		else
			op = pick < 45 ? OP_ALLOC : pick < 75 ? OP_LOAD : pick < 94 ? OP_FREE : OP_NOP;
		rtype = $urandom_range(0, 4) == 0 ? 4'($urandom) : REGION_USABLE;
		kind = $urandom_range(0, 99);
		if (kind < 45)
			base = rnd64();
		else if (kind < 95)
			base = 64'($urandom_range(0, 65535)) * FRAME;
		else
			base = TOP_FRAME - 64'($urandom_range(0, 4)) * FRAME + 64'($urandom_range(0, 7));
		kind = $urandom_range(0, 99);
		if (fill_phase && kind < 5)
			len = rnd64();
		else if (kind < 80)
			len = 64'($urandom_range(0, 4)) * FRAME + 64'($urandom_range(0, DEF_FRAME_BYTES - 1));
		else
			len = 64'($urandom_range(0, 12)) * FRAME + 64'($urandom_range(0, 3));
		add_word(op, base, len, rtype, rnd64(), $urandom_range(0, 49) == 0);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			have_word = 1'b0;
			wait_left = 0;
		end else if (!(start && !word_taken)) begin
			if (start)
				have_word = 1'b0;
			if (!have_word && word_q.size() != 0) begin
				cur = word_q.pop_front();
				have_word = 1'b1;
				wait_left = cur.gap;
			end
			if (have_word && wait_left == 0 && !(cur.drain && reply_q.size() != 0)) begin
				opcode        <= cur.opcode;
				region_base   <= cur.base;
				region_length <= cur.length;
				region_type   <= cur.rtype;
				free_address  <= cur.faddr;
				start         <= 1'b1;
			end else begin
				if (have_word && wait_left != 0)
					wait_left--;
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pool_reply_t want;
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAIL physical_frame_pool_allocator_core");
				$finish;
			end else begin
				word_taken <= start && !busy;
				if (done) begin
					if (reply_q.size() == 0) begin
						report_mismatch("unexpected word", frame_address, '0);
					end else begin
						want = reply_q.pop_front();
						if (frame_address !== want.addr)
							report_mismatch("frame_address", frame_address, want.addr);
						if (status !== want.status)
							report_mismatch("status", 64'(status), 64'(want.status));
						if (frames_free !== want.frames)
							report_mismatch("frames_free", 64'(frames_free), 64'(want.frames));
					end
				end
				if (start && !busy)
					reply_q.push_back(pool_step(op_t'(opcode), region_base, region_length,
						region_type, free_address));
			end
		end
	end

	initial begin
		// empty pool corners
		add_word(OP_ALLOC, rnd64(), rnd64(), REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_NOP, rnd64(), rnd64(), REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_FREE, rnd64(), rnd64(), 4'hF, ALL_ONES, 1'b0);
		add_word(OP_FREE, rnd64(), rnd64(), 4'h0, '0, 1'b0);
		add_word(OP_LOAD, '0, ALL_ONES, 4'h0, rnd64(), 1'b0);
		add_word(OP_LOAD, '0, ALL_ONES, 4'hF, rnd64(), 1'b0);
		add_word(OP_LOAD, '0, FRAME - 64'd1, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, '0, '0, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, 64'h1234, FRAME, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, TOP_FRAME - 64'd2 * FRAME + 64'd5, ALL_ONES, REGION_USABLE,
			rnd64(), 1'b0);
		add_word(OP_LOAD, TOP_FRAME, ALL_ONES, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, ALL_ONES, ALL_ONES, REGION_USABLE, rnd64(), 1'b0);
		repeat (7)
			add_word(OP_ALLOC, rnd64(), rnd64(), 4'($urandom), rnd64(), 1'b0);
		repeat (PHASE_WORDS)
			add_random(1'b0);
		// full pool corners
		add_word(OP_LOAD, rnd64(), ALL_ONES, REGION_USABLE, rnd64(), 1'b1);
		add_word(OP_FREE, rnd64(), rnd64(), REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_ALLOC, rnd64(), rnd64(), REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, 64'($urandom) * FRAME, FRAME, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_ALLOC, rnd64(), rnd64(), REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, rnd64(), 64'd2 * FRAME, REGION_USABLE, rnd64(), 1'b0);
		add_word(OP_LOAD, rnd64(), ALL_ONES, 4'h2, rnd64(), 1'b1);
		repeat (PHASE_WORDS)
			add_random(1'b1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (word_q.size() != 0 || have_word || start)
			@(negedge clk);
		while (reply_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("PASS physical_frame_pool_allocator_core");
		else
			$display("FAIL physical_frame_pool_allocator_core");
		$finish;
	end

endmodule
